/* hdl/lprc_pkg.sv */
// Shared types, codes and the CRC-32 byte update for the record validator.
package lprc_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [WordW-1:0] CrcInit = 32'hFFFF_FFFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PAYLOAD_SIZE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXPECTED_RECORDS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_EXPECTED_CRC     = 2'd2;

  typedef enum logic [CodeW-1:0] {
    ERR_OK         = 3'd0,
    ERR_ZERO_LEN   = 3'd1,
    ERR_TOO_LONG   = 3'd2,
    ERR_OVERRUN    = 3'd3,
    ERR_EARLY_END  = 3'd4,
    ERR_COUNT      = 3'd5,
    ERR_CRC        = 3'd6,
    ERR_TRAILING   = 3'd7
  } err_code_e;

  // Reflected CRC-32 update by one byte, unrolled over its eight bits.
  function automatic logic [WordW-1:0] lprc_crc_byte(input logic [WordW-1:0] crc,
                                                     input logic [DataW-1:0] data);
    logic [WordW-1:0] c;
    c = crc ^ {{(WordW-DataW){1'b0}}, data};
    for (int k = 0; k < DataW; k++) begin
      c = (c >> 1) ^ (CrcPoly & {WordW{c[0]}});
    end
    return c;
  endfunction

  // Checks made once the payload is complete: count, then CRC, then file end.
  function automatic err_code_e lprc_final_code(input logic [WordW-1:0] records,
                                                input logic [WordW-1:0] exp_records,
                                                input logic [WordW-1:0] crc,
                                                input logic [WordW-1:0] exp_crc,
                                                input logic           ends_here);
    err_code_e code;
    if (records != exp_records) begin
      code = ERR_COUNT;
    end else if (~crc != exp_crc) begin
      code = ERR_CRC;
    end else if (!ends_here) begin
      code = ERR_TRAILING;
    end else begin
      code = ERR_OK;
    end
    return code;
  endfunction

endpackage

/* hdl/lprc_if.sv */
// Valid/ready stream interfaces for payload words in and verdict words out.
interface lprc_in_if
  import lprc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             first_of_file;
  logic             end_of_file;

  modport source (output valid, output data_byte, output first_of_file,
                  output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input first_of_file,
                  input end_of_file, output ready);
endinterface

interface lprc_out_if
  import lprc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             valid_res;
  logic [CodeW-1:0] error_code;
  logic [WordW-1:0] records_seen;
  logic [WordW-1:0] crc_seen;

  modport source (output valid, output valid_res, output error_code,
                  output records_seen, output crc_seen, input ready);
  modport sink   (input valid, input valid_res, input error_code,
                  input records_seen, input crc_seen, output ready);
endinterface

/* hdl/length_prefixed_record_crc_validator.sv */
// A word held in the input register passes its verdict to the result register once that
// register is free or being emptied. One word per cycle while the output is not stalled,
// with one byte-wide CRC-32 step and the counters between the input and result registers.
// The input register refills while a finished verdict waits in the output register.
// Reset (asynchronous, active low) clears the record state and restores the
// configuration registers to payload size 1, one record and CRC zero.
module length_prefixed_record_crc_validator
  import lprc_pkg::*;
#(
  parameter int unsigned WORD_LIMIT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_data_i,
  lprc_in_if.sink            in_ch,
  lprc_out_if.source         out_ch
);

  // A record's content length always stays below WORD_LIMIT, so the
  // remaining-content counter only needs this many bits.
  localparam int unsigned CntW = (WORD_LIMIT > 2) ? $clog2(WORD_LIMIT) : 1;

  // Record phase codes. The unused code behaves like done.
  localparam logic [1:0] PH_DONE    = 2'd0;
  localparam logic [1:0] PH_LEN     = 2'd1;
  localparam logic [1:0] PH_CONTENT = 2'd2;

  // Configuration registers.
  logic [WordW-1:0] payload_size_q, expected_records_q, expected_crc_q;

  // Input register.
  logic             in_valid_q, in_valid_d;
  logic [DataW-1:0] in_byte_q;
  logic             in_first_q, in_eof_q;

  // Record state.
  logic [1:0]       phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] bytes_q, bytes_d;
  logic [WordW-1:0] rec_q, rec_d;
  logic [WordW-1:0] crc_q, crc_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic             out_ok_q;
  logic [CodeW-1:0] out_code_q;
  logic [WordW-1:0] out_rec_q, out_crc_q;

  logic             in_take;
  logic             advance;
  logic             res_fire;
  err_code_e        res_code;

  // Working copies of the state after an optional first-of-file clear.
  logic [1:0]       ph;
  logic [CntW-1:0]  cl;
  logic [WordW-1:0] bc, rc, crc;
  logic [WordW-1:0] crc_next;
  logic             too_long;
  logic             overrun;

  // The held word moves on whenever the output register is free or is being
  // emptied this cycle, even if this word gives no verdict.
  assign advance      = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready  = !in_valid_q || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Per-word evaluation: one CRC byte step, one 33-bit add and compare for the
  // overrun check, and the completion compares.
  always_comb begin
    ph  = phase_q;
    cl  = cnt_q;
    bc  = bytes_q;
    rc  = rec_q;
    crc = crc_q;
    if (in_first_q) begin
      ph  = PH_LEN;
      cl  = '0;
      bc  = '0;
      rc  = '0;
      crc = CrcInit;
    end

    crc_next = lprc_crc_byte(crc, in_byte_q);
    too_long = {1'b0, in_byte_q} >= 9'(WORD_LIMIT);
    overrun  = ({1'b0, bc} + 33'd1 + {25'd0, in_byte_q}) > {1'b0, payload_size_q};

    phase_d  = ph;
    cnt_d    = cl;
    bytes_d  = bc;
    rec_d    = rc;
    crc_d    = crc;
    res_fire = 1'b0;
    res_code = ERR_OK;

    case (ph)
      PH_LEN: begin
        if (bc >= payload_size_q) begin
          // Payload already complete: this length byte is one too many.
          res_fire = 1'b1;
          res_code = lprc_final_code(rc, expected_records_q, crc, expected_crc_q, 1'b0);
        end else if (in_byte_q == '0) begin
          res_fire = 1'b1;
          res_code = ERR_ZERO_LEN;
        end else if (too_long) begin
          res_fire = 1'b1;
          res_code = ERR_TOO_LONG;
        end else if (overrun) begin
          res_fire = 1'b1;
          res_code = ERR_OVERRUN;
        end else begin
          crc_d   = crc_next;
          bytes_d = bc + 32'd1;
          cnt_d   = in_byte_q[CntW-1:0];
          phase_d = PH_CONTENT;
          if (in_eof_q) begin
            res_fire = 1'b1;
            res_code = ERR_EARLY_END;
          end
        end
      end
      PH_CONTENT: begin
        crc_d   = crc_next;
        bytes_d = bc + 32'd1;
        cnt_d   = cl - CntW'(1);
        if (cnt_d == '0) begin
          rec_d   = rc + 32'd1;
          phase_d = PH_LEN;
        end
        if (cnt_d == '0 && bytes_d >= payload_size_q) begin
          res_fire = 1'b1;
          res_code = lprc_final_code(rec_d, expected_records_q, crc_d, expected_crc_q,
                                     in_eof_q);
        end else if (in_eof_q) begin
          res_fire = 1'b1;
          res_code = ERR_EARLY_END;
        end
      end
      default: begin
        // Done: bytes are dropped until the next first mark.
      end
    endcase

    if (res_fire) begin
      phase_d = PH_DONE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && res_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      phase_q            <= PH_DONE;
      cnt_q              <= '0;
      bytes_q            <= '0;
      rec_q              <= '0;
      crc_q              <= CrcInit;
      payload_size_q     <= 32'd1;
      expected_records_q <= 32'd1;
      expected_crc_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        bytes_q <= bytes_d;
        rec_q   <= rec_d;
        crc_q   <= crc_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAYLOAD_SIZE:     payload_size_q     <= cfg_data_i;
          CFG_EXPECTED_RECORDS: expected_records_q <= cfg_data_i;
          CFG_EXPECTED_CRC:     expected_crc_q     <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= in_ch.data_byte;
      in_first_q <= in_ch.first_of_file;
      in_eof_q   <= in_ch.end_of_file;
    end
    if (advance && res_fire) begin
      out_ok_q   <= (res_code == ERR_OK);
      out_code_q <= res_code;
      out_rec_q  <= rec_d;
      out_crc_q  <= ~crc_d;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.valid_res    = out_ok_q;
  assign out_ch.error_code   = out_code_q;
  assign out_ch.records_seen = out_rec_q;
  assign out_ch.crc_seen     = out_crc_q;

  // The input side only stalls behind a held word that waits on a full output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> (in_valid_q && out_valid_q && !out_ch.ready))
    else $error("input stalled without a blocked output");

  // Every verdict closes the file.
  a_verdict_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_fire) |=> (phase_q == PH_DONE && out_valid_q))
    else $error("verdict did not close the file");

  // Content phase always has content left to take.
  a_content_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CONTENT) |-> (cnt_q != '0))
    else $error("content phase with no content left");

  // The pass flag and the error code agree.
  a_pass_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_ok_q == (out_code_q == ERR_OK)))
    else $error("pass flag disagrees with error code");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the length-prefixed record validator with CRC-32.
module tb_top;
  import lprc_pkg::*;

  localparam int unsigned WordLimit   = 64;
  // Stimulus stops once this many words reached a file in progress and enough
  // verdicts have come back.
  localparam int unsigned TargetWords = 2000;
  localparam int unsigned MinVerdicts = 48;

  // Record phase of the predictor: waiting for a first mark, expecting a length
  // word, or inside the content of a record.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LENGTH,
    PH_BODY
  } rec_phase_e;

  // One expected verdict, laid out as the output word.
  typedef struct packed {
    logic             ok;
    err_code_e        code;
    logic [WordW-1:0] records;
    logic [WordW-1:0] crc;
  } verdict_t;

  // Predictor and verdict checker. It keeps its own copy of the record state and
  // of the three registers, turns each accepted input word into zero or one
  // expected verdict, and compares the verdict words in order.
  class verdict_scoreboard;
    rec_phase_e       ph;
    logic [7:0]       left;
    logic [WordW-1:0] consumed;
    logic [WordW-1:0] rec_count;
    logic [WordW-1:0] crc_reg;
    logic [WordW-1:0] cfg_size;
    logic [WordW-1:0] cfg_records;
    logic [WordW-1:0] cfg_crc;
    verdict_t         expected_q[$];
    int unsigned      failures;
    int unsigned      verdicts;
    int unsigned      words_live;
    int unsigned      words_ignored;
    int unsigned      code_hits[8];

    function new();
      ph          = PH_IDLE;
      left        = '0;
      consumed    = '0;
      rec_count   = '0;
      crc_reg     = '1;
      cfg_size    = 32'd1;
      cfg_records = 32'd1;
      cfg_crc     = '0;
      failures    = 0;
      verdicts    = 0;
      words_live  = 0;
      words_ignored = 0;
      foreach (code_hits[i]) code_hits[i] = 0;
    endfunction

    // Reflected CRC-32, one bit at a time.
    static function logic [WordW-1:0] crc_update(logic [WordW-1:0] crc, logic [7:0] b);
      logic [WordW-1:0] c;
      c = crc ^ {24'd0, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      return c;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] value);
      case (idx)
        CFG_PAYLOAD_SIZE:     cfg_size    = value;
        CFG_EXPECTED_RECORDS: cfg_records = value;
        CFG_EXPECTED_CRC:     cfg_crc     = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void post(err_code_e code);
      verdict_t v;
      v.ok      = (code == ERR_OK);
      v.code    = code;
      v.records = rec_count;
      v.crc     = ~crc_reg;
      expected_q.push_back(v);
      code_hits[int'(code)]++;
      ph = PH_IDLE;
    endfunction

    // Checks made once the payload is complete: count, CRC, then end of file.
    function err_code_e completion_code(logic ends_here);
      if (rec_count != cfg_records) return ERR_COUNT;
      if (~crc_reg != cfg_crc) return ERR_CRC;
      if (!ends_here) return ERR_TRAILING;
      return ERR_OK;
    endfunction

    function void note_word(logic [7:0] b, logic first, logic eof);
      if (first) begin
        ph        = PH_LENGTH;
        left      = '0;
        consumed  = '0;
        rec_count = '0;
        crc_reg   = '1;
      end
      if (ph == PH_IDLE) begin
        words_ignored++;
        return;
      end
      words_live++;
      if (ph == PH_LENGTH) begin
        // A payload that is already complete turns any further length word into
        // the completion checks, with the file not ending here.
        if (consumed >= cfg_size) begin
          post(completion_code(1'b0));
        end else if (b == 8'd0) begin
          post(ERR_ZERO_LEN);
        end else if (32'(b) >= WordLimit) begin
          post(ERR_TOO_LONG);
        end else if ({32'd0, consumed} + 64'd1 + 64'(b) > {32'd0, cfg_size}) begin
          post(ERR_OVERRUN);
        end else begin
          crc_reg = crc_update(crc_reg, b);
          consumed++;
          left = b;
          ph   = PH_BODY;
          if (eof) post(ERR_EARLY_END);
        end
      end else begin
        crc_reg = crc_update(crc_reg, b);
        consumed++;
        left--;
        if (left == 8'd0) begin
          rec_count++;
          if (consumed >= cfg_size) begin
            post(completion_code(eof));
            return;
          end
          ph = PH_LENGTH;
        end
        if (eof) post(ERR_EARLY_END);
      end
    endfunction

    task report(string msg);
      failures++;
      $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_verdict(logic valid_res, logic [CodeW-1:0] code,
                       logic [WordW-1:0] recs, logic [WordW-1:0] crc);
      verdict_t v;
      verdicts++;
      if (expected_q.size() == 0) begin
        report($sformatf("verdict with nothing expected: code %0d records %0d crc %08h",
                         code, recs, crc));
        return;
      end
      v = expected_q.pop_front();
      if (valid_res !== v.ok)
        report($sformatf("valid_res %b, expected %b", valid_res, v.ok));
      if (code !== v.code)
        report($sformatf("error_code %0d, expected %0d", code, v.code));
      if (recs !== v.records)
        report($sformatf("records_seen %0d, expected %0d", recs, v.records));
      if (crc !== v.crc)
        report($sformatf("crc_seen %08h, expected %08h", crc, v.crc));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [WordW-1:0]   cfg_data;

  lprc_in_if  word_in ();
  lprc_out_if verdict_out ();

  length_prefixed_record_crc_validator #(
    .WORD_LIMIT(WordLimit)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_ch     (word_in),
    .out_ch    (verdict_out)
  );

  verdict_scoreboard sb = new();

  // Chance in percent that a word is preceded by an idle burst on the input, and
  // that the output side starts a stall burst. Both change from group to group.
  int unsigned src_gap_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned reg_settings = 0;

  // The file being built: one entry per word, with its marks.
  logic [7:0] byte_q[$];
  logic       first_q[$];
  logic       eof_q[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Every verdict word is checked at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni && verdict_out.valid && verdict_out.ready) begin
      sb.check_verdict(verdict_out.valid_res, verdict_out.error_code,
                       verdict_out.records_seen, verdict_out.crc_seen);
    end
  end

  // Output pacing: ready drops in bursts that start at the chance set by sink_stall_pct.
  initial begin : sink_pacing
    int unsigned hold;
    hold = 0;
    verdict_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
        verdict_out.ready <= 1'b0;
      end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        hold = $urandom_range(0, 3);
        verdict_out.ready <= 1'b0;
      end else begin
        verdict_out.ready <= 1'b1;
      end
    end
  end

  // Offers one word at a falling edge, possibly after an idle burst, and holds it
  // until a rising edge sees valid and ready together.
  task automatic send_word(input logic [7:0] b, input logic first, input logic eof);
    int unsigned gap;
    gap = 0;
    @(negedge clk_i);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      word_in.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    word_in.valid         <= 1'b1;
    word_in.data_byte     <= b;
    word_in.first_of_file <= first;
    word_in.end_of_file   <= eof;
    @(posedge clk_i);
    while (!word_in.ready) @(posedge clk_i);
    sb.note_word(b, first, eof);
  endtask

  // Stops sending and waits until every expected verdict is in. A word that gives
  // no verdict may still be in the pipeline then, so the task waits on before it returns.
  task automatic wait_drained();
    @(negedge clk_i);
    word_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Registers change only with the block drained, so a reprogram also serves as
  // a point where the sender holds off until all verdicts have come back.
  task automatic program_regs(input logic [WordW-1:0] size, input logic [WordW-1:0] recs,
                              input logic [WordW-1:0] crc);
    wait_drained();
    write_reg(CFG_PAYLOAD_SIZE, size);
    write_reg(CFG_EXPECTED_RECORDS, recs);
    write_reg(CFG_EXPECTED_CRC, crc);
    reg_settings++;
  endtask

  task automatic send_file();
    foreach (byte_q[i]) send_word(byte_q[i], first_q[i], eof_q[i]);
  endtask

  function automatic logic [WordW-1:0] crc_of_file();
    logic [WordW-1:0] c;
    c = '1;
    foreach (byte_q[i]) c = verdict_scoreboard::crc_update(c, byte_q[i]);
    return ~c;
  endfunction

  // Builds a well-formed file of one to four records. Lengths are mostly short,
  // with the occasional long record up to the largest legal length.
  task automatic build_file(output int unsigned nrec);
    int unsigned len;
    byte_q.delete();
    first_q.delete();
    eof_q.delete();
    nrec = $urandom_range(1, 4);
    repeat (nrec) begin
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                         : $urandom_range(9, WordLimit - 1);
      first_q.push_back(byte_q.size() == 0);
      eof_q.push_back(1'b0);
      byte_q.push_back(8'(len));
      repeat (len) begin
        byte_q.push_back(8'($urandom));
        first_q.push_back(1'b0);
        eof_q.push_back(1'b0);
      end
    end
    eof_q[eof_q.size() - 1] = 1'b1;
  endtask

  // One register setting and one to three files sent under it. About half the
  // settings match the file; the rest break one thing: the expected count or CRC,
  // the end of the file, a length word, the payload size, or the marks inside the file.
  task automatic run_group(input logic quiet);
    int unsigned nrec, total, keep, mode, p, k, pos;
    logic [WordW-1:0] size, recs, crc;
    build_file(nrec);
    total = byte_q.size();
    size  = total;
    recs  = nrec;
    crc   = crc_of_file();
    mode  = $urandom_range(0, 99);
    if (mode < 45) begin
      // Matching registers: the file should pass.
    end else if (mode < 53) begin
      recs = (recs > 1 && $urandom_range(0, 1) == 1) ? recs - 1 : recs + $urandom_range(1, 3);
    end else if (mode < 61) begin
      crc = crc ^ (32'd1 << $urandom_range(0, 31));
    end else if (mode < 68) begin
      // Extra words after the payload is complete.
      eof_q[total - 1] = 1'b0;
      repeat ($urandom_range(1, 3)) begin
        byte_q.push_back(8'($urandom));
        first_q.push_back(1'b0);
        eof_q.push_back(1'b0);
      end
      eof_q[eof_q.size() - 1] = 1'b1;
    end else if (mode < 75) begin
      // The file stops short of the payload size.
      if (total > 1) begin
        keep    = $urandom_range(1, total - 1);
        byte_q  = byte_q[0:keep-1];
        first_q = first_q[0:keep-1];
        eof_q   = eof_q[0:keep-1];
        eof_q[keep - 1] = 1'b1;
      end
    end else if (mode < 81) begin
      // One length word becomes zero or too long.
      p = 0;
      k = $urandom_range(0, nrec - 1);
      repeat (k) p += byte_q[p] + 1;
      byte_q[p] = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom_range(WordLimit, 255));
    end else if (mode < 87) begin
      if (total > 1) size = $urandom_range(1, total - 1);
    end else if (mode < 93) begin
      size = total + $urandom_range(1, 20);
    end else if (mode < 97) begin
      eof_q[total - 1] = 1'b0;
    end else begin
      // Stray marks inside the file.
      repeat ($urandom_range(1, 3)) begin
        pos = $urandom_range(0, total - 1);
        if ($urandom_range(0, 1) == 1) first_q[pos] = 1'b1;
        else eof_q[pos] = ~eof_q[pos];
      end
    end

    if (quiet) begin
      src_gap_pct    = 0;
      sink_stall_pct = 0;
    end else begin
      src_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
      sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
    end
    program_regs(size, recs, crc);

    for (int c = $urandom_range(1, 3); c > 0; c--) begin
      send_file();
      if (c > 1) begin
        // The next copy is either the same file or one with a single word changed,
        // and may follow a few words that arrive outside any file.
        if ($urandom_range(0, 1) == 1 && byte_q.size() > 1) begin
          pos = $urandom_range(1, byte_q.size() - 1);
          byte_q[pos] = 8'($urandom);
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0, 1'($urandom));
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [WordW-1:0] crc;
    string            hits;
    word_in.valid         = 1'b0;
    word_in.data_byte     = '0;
    word_in.first_of_file = 1'b0;
    word_in.end_of_file   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_PAYLOAD_SIZE;
    cfg_data = '0;
    rst_ni   = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, starting from the reset registers: payload size 1, one
    // record, CRC zero.
    src_gap_pct    = 20;
    sink_stall_pct = 20;
    // A word without a first mark while no file is open is ignored.
    send_word(8'h3C, 1'b0, 1'b0);
    // Zero length, also with the end mark on it: zero length wins over early end.
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    // Lengths at the limit and at the top of the byte range are too long.
    send_word(8'(WordLimit), 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    // A one-word record does not fit in a one-word payload.
    send_word(8'h01, 1'b1, 1'b0);

    // All-ones registers: a first mark carrying the end mark ends the file early,
    // and so does an end mark right after a complete record.
    program_regs('1, '1, '1);
    send_word(8'(WordLimit - 1), 1'b1, 1'b1);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);

    // A two-word payload: pass, CRC mismatch, count mismatch, trailing words.
    byte_q = '{8'h01, 8'hA5};
    crc = crc_of_file();
    program_regs(32'd2, 32'd1, crc);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b1);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);
    program_regs(32'd2, 32'd2, crc);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b1);
    program_regs(32'd2, 32'd1, crc);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b0);

    // The payload size shrinks mid-file to what was already consumed, so the
    // next length word finds the payload complete and becomes trailing words.
    byte_q = '{8'h02, 8'h11, 8'h22};
    crc = crc_of_file();
    program_regs(32'd10, 32'd1, crc);
    send_word(8'h02, 1'b1, 1'b0);
    send_word(8'h11, 1'b0, 1'b0);
    send_word(8'h22, 1'b0, 1'b0);
    program_regs(32'd3, 32'd1, crc);
    send_word(8'h05, 1'b0, 1'b0);

    // Random part; the last stretch runs without idling on either side.
    while (sb.words_live < TargetWords || sb.verdicts < MinVerdicts) begin
      run_group(sb.words_live >= TargetWords * 85 / 100);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d verdicts never arrived", sb.pending()));

    hits = "";
    foreach (sb.code_hits[i]) hits = {hits, $sformatf(" %0d:%0d", i, sb.code_hits[i])};
    $display("Covered %0d file words, %0d ignored words, %0d register settings.",
             sb.words_live, sb.words_ignored, reg_settings);
    $display("Checked %0d verdicts; count by error code:%s", sb.verdicts, hits);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("Timeout: the run did not finish.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
hdl/lprc_pkg.sv
hdl/lprc_if.sv
hdl/length_prefixed_record_crc_validator.sv
dv/tb_top.sv
